// ===== hw/rtl/llh_pkg.sv =====
// Shared types and constants for the log2 latency histogram core.
`default_nettype none
package llh_pkg;
   localparam int NUM_BUCKETS_DEF   = 64;
   localparam int SHOWN_BUCKETS_DEF = 22;
   localparam int STAR_SCALE_DEF    = 40;
   localparam logic [9:0] NS_PER_US = 10'd1000;

   localparam logic [1:0] ROW_BUCKET   = 2'd0;
   localparam logic [1:0] ROW_OVERFLOW = 2'd1;
   localparam logic [1:0] ROW_TOTALS   = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] group_id;
      logic [63:0] duration_ns;
   } req_type;

   typedef struct packed {
      logic [1:0]  row_kind;
      logic [4:0]  bucket;
      logic [63:0] count;
      logic [5:0]  stars;
      logic [63:0] interval_total_ns;
      logic [63:0] running_total_ns;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/latency_log2_histogram_core.sv =====
// Top level of the log2 latency histogram core.
// A histogram-mode sample steps through bin and address, memory read, write back.
// A filter-mode sample is absorbed in idle; a filter tick emits a totals row past output stalls.
// A histogram tick scans every bucket, then fetches up to E, the last shown bucket, then builds
// each row in the bit-serial bar divider, waiting out output stalls.
// After reset a clearing pass over all NUM_BUCKETS entries zeroes the bucket memory.
`default_nettype none
module latency_log2_histogram_core
   import llh_pkg::*;
#(
   parameter int NUM_BUCKETS   = NUM_BUCKETS_DEF,
   parameter int SHOWN_BUCKETS = SHOWN_BUCKETS_DEF,
   parameter int STAR_SCALE    = STAR_SCALE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [31:0] csr_wdata
);
   localparam int AW = $clog2(NUM_BUCKETS);
   localparam int CW = $clog2(STAR_SCALE + 2);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_WR, S_SCAN, S_SCAN2, S_ROW_RD, S_ROW_DIV,
      S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] filter_ff;
   logic [63:0] interval_ff, running_ff;
   logic [63:0] mem [NUM_BUCKETS];
   logic [63:0] rdata_ff;
   logic [AW-1:0] addr_ff;
   logic [AW:0]   idx_ff;
   logic [AW-1:0] last_nz_ff;
   logic [63:0] over_ff, max_ff;
   logic [AW-1:0] end_ff;
   logic [63:0] cnt_ff, brem_ff;
   logic [CW-1:0] bq_ff, bstep_ff;
   logic        over_row_ff, pend_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [63:0] diff;
   logic [AW-1:0] bin_idx;

   assign diff = max_ff - cnt_ff;
   assign req_stall = (state_ff != S_IDLE) || reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The duration reaches bucket k when it is at least 1000 * 2^k nanoseconds.
   always_comb begin
      bin_idx = '0;
      for (int k = 1; k < 64; k++) begin
         if ({10'd0, req_data.duration_ns} >= (74'(NS_PER_US) << k)) begin
            bin_idx = (k > NUM_BUCKETS - 1) ? AW'(NUM_BUCKETS - 1) : AW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR || state_ff == S_WR) begin
         mem[addr_ff] <= (state_ff == S_CLEAR) ? 64'd0 : rdata_ff + 64'd1;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         filter_ff    <= '0;
         interval_ff  <= '0;
         running_ff   <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            filter_ff <= csr_wdata;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + AW'(1);
               if (addr_ff == AW'(NUM_BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  if (req_data.kind == KIND_SAMPLE) begin
                     if (filter_ff == '0) begin
                        addr_ff  <= bin_idx;
                        state_ff <= S_RD;
                     end else if (req_data.group_id == filter_ff) begin
                        interval_ff <= interval_ff + req_data.duration_ns;
                     end
                  end else if (filter_ff != '0) begin
                     running_ff   <= running_ff + interval_ff;
                     rsp_ff       <= '{ROW_TOTALS, 5'd0, 64'd0, 6'd0, interval_ff,
                                       running_ff + interval_ff, 1'b1};
                     rsp_valid_ff <= 1'b1;
                     interval_ff  <= '0;
                     state_ff     <= S_OUT;
                     pend_ff      <= 1'b0;
                  end else begin
                     interval_ff <= '0;
                     idx_ff      <= '0;
                     addr_ff     <= '0;
                     last_nz_ff  <= '0;
                     over_ff     <= '0;
                     max_ff      <= '0;
                     state_ff    <= S_SCAN;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_WR;
            end
            S_WR: begin
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               // Pass one: last nonzero bucket and overflow sum; rdata lags addr.
               if (idx_ff != '0) begin
                  if (rdata_ff != '0) begin
                     last_nz_ff <= AW'(idx_ff - 1'b1);
                  end
                  if ((idx_ff - 1'b1) >= (AW+1)'(SHOWN_BUCKETS)) begin
                     over_ff <= over_ff + rdata_ff;
                  end
               end
               if (idx_ff == (AW+1)'(NUM_BUCKETS)) begin
                  idx_ff   <= '0;
                  addr_ff  <= '0;
                  state_ff <= S_SCAN2;
                  if (last_nz_ff < AW'(SHOWN_BUCKETS - 1) &&
                      !(rdata_ff != '0 && AW'(idx_ff - 1'b1) >= AW'(SHOWN_BUCKETS - 1))) begin
                     end_ff <= (rdata_ff != '0) ? AW'(idx_ff - 1'b1) : last_nz_ff;
                  end else begin
                     end_ff <= AW'(SHOWN_BUCKETS - 1);
                  end
               end else begin
                  idx_ff  <= idx_ff + 1'b1;
                  addr_ff <= AW'(idx_ff + 1'b1);
               end
            end
            S_SCAN2: begin
               if (end_ff < AW'(SHOWN_BUCKETS - 1) || last_nz_ff <= AW'(SHOWN_BUCKETS - 1)) begin
                  if (idx_ff == '0) begin
                     over_ff <= over_ff;
                  end
               end
               if (idx_ff != '0 && rdata_ff > max_ff) begin
                  max_ff <= rdata_ff;
               end
               if (idx_ff == (AW+1)'(end_ff) + 1'b1) begin
                  if (over_ff > max_ff && !(idx_ff != '0 && rdata_ff > over_ff)) begin
                     max_ff <= over_ff;
                  end
                  idx_ff      <= '0;
                  addr_ff     <= '0;
                  over_row_ff <= 1'b0;
                  pend_ff     <= 1'b1;
                  state_ff    <= S_OUT;
               end else begin
                  idx_ff  <= idx_ff + 1'b1;
                  addr_ff <= AW'(idx_ff + 1'b1);
               end
            end
            S_ROW_RD: begin
               cnt_ff   <= over_row_ff ? over_ff : rdata_ff;
               brem_ff  <= '0;
               bq_ff    <= '0;
               bstep_ff <= '0;
               state_ff <= S_ROW_DIV;
            end
            S_ROW_DIV: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  if (bstep_ff < CW'(STAR_SCALE)) begin
                     if (brem_ff >= diff) begin
                        brem_ff <= brem_ff - diff;
                        bq_ff   <= bq_ff + CW'(1);
                     end else begin
                        brem_ff <= brem_ff + cnt_ff;
                     end
                     bstep_ff <= bstep_ff + CW'(1);
                  end else begin
                     rsp_ff.row_kind <= over_row_ff ? ROW_OVERFLOW : ROW_BUCKET;
                     rsp_ff.bucket   <= over_row_ff ? 5'd0 : 5'(idx_ff);
                     rsp_ff.count    <= cnt_ff;
                     rsp_ff.stars    <= (max_ff == '0) ? 6'd0 :
                        6'(bq_ff + ((brem_ff >= max_ff - brem_ff) ? CW'(1) : CW'(0)));
                     rsp_ff.interval_total_ns <= '0;
                     rsp_ff.running_total_ns  <= '0;
                     rsp_valid_ff <= 1'b1;
                     if (over_row_ff) begin
                        rsp_ff.last <= 1'b1;
                        pend_ff     <= 1'b0;
                     end else if (idx_ff == (AW+1)'(end_ff)) begin
                        rsp_ff.last <= (over_ff == '0);
                        pend_ff     <= (over_ff != '0);
                        over_row_ff <= 1'b1;
                     end else begin
                        rsp_ff.last <= 1'b0;
                        pend_ff     <= 1'b1;
                        idx_ff      <= idx_ff + 1'b1;
                        addr_ff     <= AW'(idx_ff + 1'b1);
                     end
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= pend_ff ? S_ROW_RD : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the log2 latency histogram core.
`default_nettype none
module tb_top;
   import llh_pkg::*;

   localparam int NB = NUM_BUCKETS_DEF;
   localparam int SB = SHOWN_BUCKETS_DEF;
   localparam int BW = STAR_SCALE_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [31:0] csr_wdata = '0;

   latency_log2_histogram_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rows[$];
   int unsigned error_count = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned hold_left = 0;
   bit hold_request = 1'b0;
   int unsigned stall_phase = 0;

   logic [31:0] model_filter = '0;
   logic [63:0] model_buckets[NB];
   logic [63:0] model_interval = '0;
   logic [63:0] model_running = '0;

   function automatic int unsigned bucket_index(logic [63:0] ns);
      logic [63:0] us;
      int unsigned idx;
      us = ns / 64'd1000;
      idx = 0;
      while (us > 64'd1) begin
         us = us >> 1;
         idx++;
      end
      if (idx > NB - 1) idx = NB - 1;
      return idx;
   endfunction

   function automatic logic [5:0] star_count(logic [63:0] cnt, logic [63:0] mx);
      logic [63:0] q, rem;
      q = 0;
      rem = 0;
      if (mx == 0) return 6'd0;
      if (cnt > mx) cnt = mx;
      for (int i = 0; i < BW; i++) begin
         if (rem >= mx - cnt) begin
            rem -= mx - cnt;
            q++;
         end else begin
            rem += cnt;
         end
      end
      if (rem >= mx - rem) q++;
      if (q > BW) q = BW;
      return q[5:0];
   endfunction

   task automatic predict_rows(req_type it);
      rsp_type row;
      int unsigned last_nz, last_row;
      logic [63:0] over, mx;
      last_nz = 0;
      over = 0;
      mx = 0;
      if (it.kind == KIND_SAMPLE) begin
         if (model_filter == 0) model_buckets[bucket_index(it.duration_ns)] += 64'd1;
         else if (it.group_id == model_filter) model_interval += it.duration_ns;
         return;
      end
      if (model_filter != 0) begin
         model_running += model_interval;
         row = '0;
         row.row_kind = ROW_TOTALS;
         row.interval_total_ns = model_interval;
         row.running_total_ns = model_running;
         row.last = 1'b1;
         expected_rows.push_back(row);
         model_interval = 0;
         return;
      end
      model_interval = 0;
      for (int b = 0; b < NB; b++) if (model_buckets[b] != 0) last_nz = b;
      last_row = (last_nz < SB - 1) ? last_nz : SB - 1;
      if (last_nz > SB - 1) for (int b = SB; b < NB; b++) over += model_buckets[b];
      for (int b = 0; b <= last_row; b++) if (model_buckets[b] > mx) mx = model_buckets[b];
      if (over > mx) mx = over;
      for (int b = 0; b <= last_row; b++) begin
         row = '0;
         row.row_kind = ROW_BUCKET;
         row.bucket = b[4:0];
         row.count = model_buckets[b];
         row.stars = star_count(model_buckets[b], mx);
         row.last = (b == last_row) && (over == 0);
         expected_rows.push_back(row);
      end
      if (over != 0) begin
         row = '0;
         row.row_kind = ROW_OVERFLOW;
         row.count = over;
         row.stars = star_count(over, mx);
         row.last = 1'b1;
         expected_rows.push_back(row);
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // The driver offers transactions in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
      end else begin
         if (req_valid) predict_rows(req_data);
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls on its own pattern, with an occasional long hold-off.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else if (stall_phase[8]) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // The monitor checks each result transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected result transaction", rsp_data.count, 64'd0);
         end else begin
            want = expected_rows.pop_front();
            if (rsp_data.row_kind != want.row_kind)
               report_mismatch("row_kind", rsp_data.row_kind, want.row_kind);
            if (rsp_data.bucket != want.bucket)
               report_mismatch("bucket", rsp_data.bucket, want.bucket);
            if (rsp_data.count != want.count)
               report_mismatch("count", rsp_data.count, want.count);
            if (rsp_data.stars != want.stars)
               report_mismatch("stars", rsp_data.stars, want.stars);
            if (rsp_data.interval_total_ns != want.interval_total_ns)
               report_mismatch("interval_total_ns", rsp_data.interval_total_ns,
                               want.interval_total_ns);
            if (rsp_data.running_total_ns != want.running_total_ns)
               report_mismatch("running_total_ns", rsp_data.running_total_ns,
                               want.running_total_ns);
            if (rsp_data.last != want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   function automatic req_type make_req(logic k, logic [31:0] g, logic [63:0] ns);
      req_type r;
      r.kind = k;
      r.group_id = g;
      r.duration_ns = ns;
      return r;
   endfunction

   function automatic logic [63:0] random_ns();
      int unsigned sh;
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return v;
         1: return v >> $urandom_range(0, 63);
         default: begin
            sh = $urandom_range(0, 34);
            return v >> (64 - sh);
         end
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rows.size() > 0)
         @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   task automatic write_filter(logic [31:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      model_filter = v;
   endtask

   task automatic random_phase(int n, logic [31:0] grp);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0)
            pending_reqs.push_back(make_req(KIND_TICK, $urandom, random_ns()));
         else
            pending_reqs.push_back(make_req(KIND_SAMPLE,
               ($urandom_range(0, 2) != 0) ? grp : $urandom, random_ns()));
      end
      pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
   endtask

   initial begin
      for (int b = 0; b < NB; b++) model_buckets[b] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // Directed: empty histogram, small and extreme durations, overflow.
      pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'hFFFF_FFFF, 64'd0));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, 64'd1999));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, 64'd2000));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, 64'd999_999));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, 64'd4194303000));
      pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, 64'd4194304000));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, '1));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 0, '1));
      pending_reqs.push_back(make_req(KIND_TICK, 32'hFFFF_FFFF, '1));
      wait_idle();
      write_filter(32'hFFFF_FFFF);
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'hFFFF_FFFF, '1));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'hFFFF_FFFF, 64'd5));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'd7, 64'd9));
      pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'hFFFF_FFFF, 64'd3));
      pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
      random_phase(60, 32'hFFFF_FFFF);
      wait_idle();
      write_filter(32'd1);
      random_phase(60, 32'd1);
      wait_idle();
      // Leftover interval sum is discarded by a histogram tick.
      pending_reqs.push_back(make_req(KIND_SAMPLE, 32'd1, 64'd777));
      wait_idle();
      write_filter(32'd0);
      random_phase(80, 32'd0);
      wait_idle();
      // Long receiver hold-off while many ticks queue up.
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(KIND_TICK, 0, 0));
      random_phase(80, $urandom);
      wait_idle();
      write_filter($urandom | 32'h1);
      random_phase(40, model_filter);
      wait_idle();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
